[src/bmc_pkg.sv]
// Shared types, constants and the control word layout of the maze carver.
`default_nettype none

package bmc_pkg;

  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  localparam logic [6:0] GRID_WIDTH_RST  = 7'd17;
  localparam logic [6:0] GRID_HEIGHT_RST = 7'd8;

  // Configuration register indexes.
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Command opcodes.
  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  // Microprogram entry points.
  localparam upc_t UPC_IDLE     = 4'd0;
  localparam upc_t UPC_DISPATCH = 4'd1;
  localparam upc_t UPC_CLEAR    = 4'd2;
  localparam upc_t UPC_BEGIN    = 4'd3;
  localparam upc_t UPC_STEP     = 4'd4;
  localparam upc_t UPC_LOAD_TOP = 4'd5;
  localparam upc_t UPC_SCAN0    = 4'd6;
  localparam upc_t UPC_SCAN1    = 4'd7;
  localparam upc_t UPC_SCAN2    = 4'd8;
  localparam upc_t UPC_SCAN3    = 4'd9;
  localparam upc_t UPC_SCAN4    = 4'd10;
  localparam upc_t UPC_DECIDE   = 4'd11;
  localparam upc_t UPC_POP      = 4'd12;
  localparam upc_t UPC_PUSH     = 4'd13;
  localparam upc_t UPC_FINISH   = 4'd14;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LATCH,
    ACT_CLEAR,
    ACT_BEGIN,
    ACT_LOAD_TOP,
    ACT_POP,
    ACT_PUSH,
    ACT_FINISH
  } act_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_WAIT,
    COND_STEP,
    COND_CLR_MORE,
    COND_EMPTY,
    COND_HAS_OPEN
  } cond_t;

  typedef struct packed {
    act_t  act;
    dir_t  rd_dir;
    logic  scan_cap;
    dir_t  cap_dir;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  typedef struct packed {
    logic op_step;
    logic clr_more;
    logic empty;
    logic has_open;
  } stat_t;

  function automatic ctrl_t mk_word(input act_t act, input dir_t rd_dir, input logic scan_cap,
                                    input dir_t cap_dir, input cond_t cond, input upc_t target);
    ctrl_t w;
    w.act      = act;
    w.rd_dir   = rd_dir;
    w.scan_cap = scan_cap;
    w.cap_dir  = cap_dir;
    w.cond     = cond;
    w.target   = target;
    return w;
  endfunction

  // Remainder by three of a 16-bit value: base-4 digits each count one mod 3.
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    logic [2:0] r;
    s = 5'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      r = t - 3'd6;
    end else if (t >= 3'd3) begin
      r = t - 3'd3;
    end else begin
      r = t;
    end
    return r[1:0];
  endfunction

endpackage

`default_nettype wire

[src/bmc_ucode_rom.sv]
// Microprogram store: one control word per step of the carver's sequencer.
`default_nettype none

module bmc_ucode_rom (
  input  wire  bmc_pkg::upc_t  upc,
  output bmc_pkg::ctrl_t       ctrl
);

  always_comb begin
    unique case (upc)
      bmc_pkg::UPC_IDLE: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_LATCH, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_WAIT, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_DISPATCH: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_STEP, bmc_pkg::UPC_STEP);
      end
      bmc_pkg::UPC_CLEAR: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_CLEAR, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_CLR_MORE, bmc_pkg::UPC_CLEAR);
      end
      bmc_pkg::UPC_BEGIN: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_BEGIN, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_ALWAYS, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_STEP: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_EMPTY, bmc_pkg::UPC_FINISH);
      end
      bmc_pkg::UPC_LOAD_TOP: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_LOAD_TOP, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      // Reads of the four neighbors overlap with capture of the previous one.
      bmc_pkg::UPC_SCAN0: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_SCAN1: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_DOWN, 1'b1, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_SCAN2: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_LEFT, 1'b1, bmc_pkg::DIR_DOWN,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_SCAN3: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_RIGHT, 1'b1, bmc_pkg::DIR_LEFT,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_SCAN4: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b1, bmc_pkg::DIR_RIGHT,
                                bmc_pkg::COND_NONE, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_DECIDE: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_HAS_OPEN, bmc_pkg::UPC_PUSH);
      end
      bmc_pkg::UPC_POP: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_POP, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_ALWAYS, bmc_pkg::UPC_STEP);
      end
      bmc_pkg::UPC_PUSH: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_PUSH, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_ALWAYS, bmc_pkg::UPC_IDLE);
      end
      bmc_pkg::UPC_FINISH: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_FINISH, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_ALWAYS, bmc_pkg::UPC_IDLE);
      end
      default: begin
        ctrl = bmc_pkg::mk_word(bmc_pkg::ACT_NONE, bmc_pkg::DIR_UP, 1'b0, bmc_pkg::DIR_UP,
                                bmc_pkg::COND_ALWAYS, bmc_pkg::UPC_IDLE);
      end
    endcase
  end

endmodule

`default_nettype wire

[src/bmc_sequencer.sv]
// Step counter with conditional jumps that walks the microprogram.
`default_nettype none

module bmc_sequencer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  start,
  input  wire  bmc_pkg::stat_t stat,
  output bmc_pkg::ctrl_t       ctrl,
  output logic                 busy
);

  bmc_pkg::upc_t upc_r;
  bmc_pkg::upc_t upc_nxt;
  logic          take_jump;

  bmc_ucode_rom u_rom (
    .upc  (upc_r),
    .ctrl (ctrl)
  );

  always_comb begin
    unique case (ctrl.cond)
      bmc_pkg::COND_NONE:     take_jump = 1'b0;
      bmc_pkg::COND_ALWAYS:   take_jump = 1'b1;
      bmc_pkg::COND_WAIT:     take_jump = ~start;
      bmc_pkg::COND_STEP:     take_jump = stat.op_step;
      bmc_pkg::COND_CLR_MORE: take_jump = stat.clr_more;
      bmc_pkg::COND_EMPTY:    take_jump = stat.empty;
      bmc_pkg::COND_HAS_OPEN: take_jump = stat.has_open;
      default:                take_jump = 1'b1;
    endcase
  end

  always_comb begin
    if (take_jump) begin
      upc_nxt = ctrl.target;
    end else begin
      upc_nxt = upc_r + bmc_pkg::upc_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= bmc_pkg::UPC_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign busy = (upc_r != bmc_pkg::UPC_IDLE);

endmodule

`default_nettype wire

[src/bmc_datapath.sv]
// Carver datapath: grid registers, visited map, path stack and result registers.
`default_nettype none

module bmc_datapath #(
  parameter int MAX_WIDTH  = bmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmc_pkg::MAX_HEIGHT_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  bmc_pkg::ctrl_t ctrl,
  output bmc_pkg::stat_t       stat,
  input  wire                  start,
  input  wire                  in_opcode,
  input  wire  [15:0]          in_random_value,
  input  wire                  cfg_we,
  input  wire                  cfg_index,
  input  wire  [6:0]           cfg_data,
  output logic                 out_strobe,
  output logic                 out_carved,
  output logic [5:0]           out_wall_x,
  output logic [5:0]           out_wall_y,
  output logic [5:0]           out_cell_x,
  output logic [5:0]           out_cell_y,
  output logic                 out_finished
);

  localparam int HALF_W     = MAX_WIDTH / 2;
  localparam int HALF_H     = MAX_HEIGHT / 2;
  localparam int CELL_COUNT = HALF_W * HALF_H;
  localparam int CXW        = $clog2(HALF_W);
  localparam int CYW        = $clog2(HALF_H);
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int DW         = $clog2(CELL_COUNT + 1);

  function automatic logic [AW-1:0] cell_idx(input logic [CXW-1:0] cx,
                                             input logic [CYW-1:0] cy);
    return AW'(AW'(cy) * AW'(HALF_W) + AW'(cx));
  endfunction

  logic [6:0]          grid_w_r;
  logic [6:0]          grid_h_r;
  logic [DW-1:0]       depth_r;
  logic                out_strobe_r;

  logic                op_r;
  logic [15:0]         rnd_r;
  logic [1:0]          mod3_r;
  logic [AW-1:0]       clr_addr_r;
  logic [CXW-1:0]      top_cx_r;
  logic [CYW-1:0]      top_cy_r;
  logic [3:0]          open_r;
  logic                carved_r;
  logic [5:0]          wall_x_r;
  logic [5:0]          wall_y_r;
  logic [5:0]          cell_x_r;
  logic [5:0]          cell_y_r;
  logic                finished_r;

  logic                vis_mem [CELL_COUNT];
  logic [CYW+CXW-1:0]  stk_mem [CELL_COUNT];
  logic                vis_q;
  logic [CYW+CXW-1:0]  stk_q;

  logic                vis_we;
  logic [AW-1:0]       vis_waddr;
  logic                vis_wdata;
  logic [AW-1:0]       vis_raddr;
  logic                stk_we;
  logic [AW-1:0]       stk_waddr;
  logic [CYW+CXW-1:0]  stk_wdata;
  logic [AW-1:0]       stk_raddr;

  logic [8:0]          w_eff;
  logic [8:0]          h_eff;
  logic                x_ok;
  logic                y_ok;
  logic [3:0]          inb;
  logic [CXW-1:0]      nb_cx [4];
  logic [CYW-1:0]      nb_cy [4];
  logic [2:0]          open_cnt;
  logic [1:0]          pick;
  bmc_pkg::dir_t       pick_dir;
  logic [CXW-1:0]      sel_cx;
  logic [CYW-1:0]      sel_cy;
  logic                stk_room;
  logic                accept;

  assign accept   = start && (ctrl.act == bmc_pkg::ACT_LATCH);
  assign stk_room = (depth_r < DW'(CELL_COUNT));

  // Grid sizes above the maximum count as the maximum.
  assign w_eff = (9'(grid_w_r) > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : 9'(grid_w_r);
  assign h_eff = (9'(grid_h_r) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(grid_h_r);

  // A neighbor two squares away must lie strictly inside the border walls. The grid
  // may have shrunk under the top cell, so the unchanged coordinate is checked too.
  assign x_ok = ((10'({top_cx_r, 1'b0}) + 10'd2) < 10'(w_eff));
  assign y_ok = ((10'({top_cy_r, 1'b0}) + 10'd2) < 10'(h_eff));
  assign inb[bmc_pkg::DIR_UP]    = (top_cy_r != '0) && x_ok &&
                                   (10'({top_cy_r, 1'b0}) < 10'(h_eff));
  assign inb[bmc_pkg::DIR_DOWN]  = x_ok && ((10'({top_cy_r, 1'b0}) + 10'd4) < 10'(h_eff));
  assign inb[bmc_pkg::DIR_LEFT]  = (top_cx_r != '0) && y_ok &&
                                   (10'({top_cx_r, 1'b0}) < 10'(w_eff));
  assign inb[bmc_pkg::DIR_RIGHT] = y_ok && ((10'({top_cx_r, 1'b0}) + 10'd4) < 10'(w_eff));

  assign nb_cx[bmc_pkg::DIR_UP]    = top_cx_r;
  assign nb_cy[bmc_pkg::DIR_UP]    = top_cy_r - CYW'(1);
  assign nb_cx[bmc_pkg::DIR_DOWN]  = top_cx_r;
  assign nb_cy[bmc_pkg::DIR_DOWN]  = top_cy_r + CYW'(1);
  assign nb_cx[bmc_pkg::DIR_LEFT]  = top_cx_r - CXW'(1);
  assign nb_cy[bmc_pkg::DIR_LEFT]  = top_cy_r;
  assign nb_cx[bmc_pkg::DIR_RIGHT] = top_cx_r + CXW'(1);
  assign nb_cy[bmc_pkg::DIR_RIGHT] = top_cy_r;

  assign vis_raddr = inb[ctrl.rd_dir] ? cell_idx(nb_cx[ctrl.rd_dir], nb_cy[ctrl.rd_dir])
                                      : '0;
  assign stk_raddr = AW'(depth_r - DW'(1));

  assign open_cnt = 3'($countones(open_r));

  always_comb begin
    unique case (open_cnt)
      3'd2:    pick = {1'b0, rnd_r[0]};
      3'd3:    pick = mod3_r;
      3'd4:    pick = rnd_r[1:0];
      default: pick = 2'd0;
    endcase
  end

  // The pick-th open neighbor in the order up, down, left, right.
  always_comb begin
    logic [1:0] seen;
    logic       found;
    seen     = 2'd0;
    found    = 1'b0;
    pick_dir = bmc_pkg::DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (open_r[d] && !found) begin
        if (seen == pick) begin
          pick_dir = bmc_pkg::dir_t'(2'(d));
          found    = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  assign sel_cx = nb_cx[pick_dir];
  assign sel_cy = nb_cy[pick_dir];

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = clr_addr_r;
    vis_wdata = 1'b0;
    stk_we    = 1'b0;
    stk_waddr = depth_r[AW-1:0];
    stk_wdata = {sel_cy, sel_cx};
    unique case (ctrl.act)
      bmc_pkg::ACT_CLEAR: begin
        vis_we = 1'b1;
      end
      bmc_pkg::ACT_BEGIN: begin
        // Cell (1,1) has index zero and goes to the bottom of the stack.
        vis_we    = 1'b1;
        vis_waddr = '0;
        vis_wdata = 1'b1;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
      end
      bmc_pkg::ACT_PUSH: begin
        vis_we    = 1'b1;
        vis_waddr = cell_idx(sel_cx, sel_cy);
        vis_wdata = 1'b1;
        stk_we    = stk_room;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_q <= vis_mem[vis_raddr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_q <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r     <= bmc_pkg::GRID_WIDTH_RST;
      grid_h_r     <= bmc_pkg::GRID_HEIGHT_RST;
      depth_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bmc_pkg::CFG_GRID_WIDTH:  grid_w_r <= cfg_data;
          bmc_pkg::CFG_GRID_HEIGHT: grid_h_r <= cfg_data;
        endcase
      end
      unique case (ctrl.act)
        bmc_pkg::ACT_BEGIN: depth_r <= DW'(1);
        bmc_pkg::ACT_POP:   depth_r <= depth_r - DW'(1);
        bmc_pkg::ACT_PUSH: begin
          if (stk_room) begin
            depth_r <= depth_r + DW'(1);
          end
        end
        default: begin
        end
      endcase
      out_strobe_r <= (ctrl.act == bmc_pkg::ACT_BEGIN) || (ctrl.act == bmc_pkg::ACT_PUSH) ||
                      (ctrl.act == bmc_pkg::ACT_FINISH);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_opcode;
      rnd_r      <= in_random_value;
      mod3_r     <= bmc_pkg::mod3_16(in_random_value);
      clr_addr_r <= '0;
    end
    if (ctrl.act == bmc_pkg::ACT_CLEAR) begin
      clr_addr_r <= clr_addr_r + AW'(1);
    end
    if (ctrl.act == bmc_pkg::ACT_LOAD_TOP) begin
      top_cx_r <= stk_q[CXW-1:0];
      top_cy_r <= stk_q[CYW+CXW-1:CXW];
    end
    if (ctrl.scan_cap) begin
      open_r[ctrl.cap_dir] <= inb[ctrl.cap_dir] & ~vis_q;
    end
    unique case (ctrl.act)
      bmc_pkg::ACT_BEGIN, bmc_pkg::ACT_FINISH: begin
        carved_r   <= 1'b0;
        wall_x_r   <= '0;
        wall_y_r   <= '0;
        cell_x_r   <= '0;
        cell_y_r   <= '0;
        finished_r <= (ctrl.act == bmc_pkg::ACT_FINISH);
      end
      bmc_pkg::ACT_PUSH: begin
        // The wall square sits halfway: (2a+1 + 2b+1) / 2 = a + b + 1.
        carved_r   <= 1'b1;
        wall_x_r   <= 6'(9'(top_cx_r) + 9'(sel_cx) + 9'd1);
        wall_y_r   <= 6'(9'(top_cy_r) + 9'(sel_cy) + 9'd1);
        cell_x_r   <= 6'(9'({sel_cx, 1'b1}));
        cell_y_r   <= 6'(9'({sel_cy, 1'b1}));
        finished_r <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign stat.op_step  = (op_r == bmc_pkg::OP_STEP);
  assign stat.clr_more = (clr_addr_r != AW'(CELL_COUNT - 1));
  assign stat.empty    = (depth_r == '0);
  assign stat.has_open = (open_r != 4'd0);

  assign out_strobe   = out_strobe_r;
  assign out_carved   = carved_r;
  assign out_wall_x   = wall_x_r;
  assign out_wall_y   = wall_y_r;
  assign out_cell_x   = cell_x_r;
  assign out_cell_y   = cell_y_r;
  assign out_finished = finished_r;

endmodule

`default_nettype wire

[src/backtracking_maze_carver.sv]
// Top level of the recursive-backtracker maze carver.
//
// Usage: a command is accepted at a rising edge with start high and busy low.
// in_opcode selects begin (clear the visited map, push cell (1,1)) or step
// (carve one wall). Each command returns exactly one result transaction,
// shown for one cycle with out_strobe high; the receiver cannot stall it.
// Configuration (cfg_we, cfg_index, cfg_data) sets the grid width and height and
// must be written only while busy is low and no result is pending; not enforced.
//
// A step that carves loads the stack top, scans the neighbors and decides, and
// repeats these for each exhausted cell popped off the stack on the way. A step
// that finds the stack empty goes straight to its finished result. A begin runs
// the clearing sweep that writes the visited map one entry per cycle over all
// CELL_COUNT entries (CELL_COUNT = MAX_WIDTH/2 * MAX_HEIGHT/2). The single read
// port of the visited map makes each step's neighbor scan read the four
// neighbors one after another.
// Reset empties the stack and restores the grid registers; the visited map is
// not cleared at reset because every begin sweeps it before use.
`default_nettype none

module backtracking_maze_carver #(
  parameter int MAX_WIDTH  = bmc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bmc_pkg::MAX_HEIGHT_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_opcode,
  input  wire  [15:0] in_random_value,
  output logic        out_strobe,
  output logic        out_carved,
  output logic [5:0]  out_wall_x,
  output logic [5:0]  out_wall_y,
  output logic [5:0]  out_cell_x,
  output logic [5:0]  out_cell_y,
  output logic        out_finished,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [6:0]  cfg_data
);

  bmc_pkg::ctrl_t ctrl;
  bmc_pkg::stat_t stat;

  bmc_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  bmc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .start           (start),
    .in_opcode       (in_opcode),
    .in_random_value (in_random_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_strobe      (out_strobe),
    .out_carved      (out_carved),
    .out_wall_x      (out_wall_x),
    .out_wall_y      (out_wall_y),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_finished    (out_finished)
  );

endmodule

`default_nettype wire

[src/bmc_checker.sv]
// Port-level checks on the maze carver, bound to the top level.
`default_nettype none

module bmc_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       start,
  input wire       busy,
  input wire       out_strobe,
  input wire       out_carved,
  input wire [5:0] out_wall_x,
  input wire [5:0] out_wall_y,
  input wire [5:0] out_cell_x,
  input wire [5:0] out_cell_y,
  input wire       out_finished
);

  // A result is shown only once the command has fully completed.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result transactions in consecutive cycles");

  a_no_carve_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_carved) |->
      (out_wall_x == 6'd0 && out_wall_y == 6'd0 && out_cell_x == 6'd0 && out_cell_y == 6'd0))
    else $error("non-carving result has nonzero coordinates");

  a_carve_cell_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_carved) |-> (!out_finished && out_cell_x[0] && out_cell_y[0]))
    else $error("carved result with a bad cell or finished flag");

endmodule

bind backtracking_maze_carver bmc_checker u_bmc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_carved   (out_carved),
  .out_wall_x   (out_wall_x),
  .out_wall_y   (out_wall_y),
  .out_cell_x   (out_cell_x),
  .out_cell_y   (out_cell_y),
  .out_finished (out_finished)
);

`default_nettype wire

[sim/tb_backtracking_maze_carver.sv]
// Self-checking testbench for the maze carver: queued commands and grid writes, predicted results.
module tb_backtracking_maze_carver;

  localparam int HALF_W    = bmc_pkg::MAX_WIDTH_DEF / 2;
  localparam int HALF_H    = bmc_pkg::MAX_HEIGHT_DEF / 2;
  localparam int CELLS     = HALF_W * HALF_H;
  localparam int N_ITEMS   = 600;
  localparam int MAX_PRINT = 50;

  typedef enum logic {
    JOB_CMD,
    JOB_CFG
  } job_kind_t;

  typedef struct {
    job_kind_t   kind;
    logic        op;
    logic [15:0] rnd;
    logic        idx;
    logic [6:0]  val;
    int          gap;
  } job_t;

  typedef struct packed {
    logic       carved;
    logic [5:0] wall_x;
    logic [5:0] wall_y;
    logic [5:0] cell_x;
    logic [5:0] cell_y;
    logic       finished;
  } maze_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_opcode = bmc_pkg::OP_BEGIN;
  logic [15:0] in_random_value = '0;
  logic        out_strobe;
  logic        out_carved;
  logic [5:0]  out_wall_x;
  logic [5:0]  out_wall_y;
  logic [5:0]  out_cell_x;
  logic [5:0]  out_cell_y;
  logic        out_finished;
  logic        cfg_we = 1'b0;
  logic        cfg_index = bmc_pkg::CFG_GRID_WIDTH;
  logic [6:0]  cfg_data = '0;

  job_t         jobs[$];
  maze_result_t expected_q[$];

  // Predictor state: visited cells, the backtracking trail and the grid registers.
  bit         seen_cell [CELLS];
  int         trail [CELLS];
  int         trail_len = 0;
  logic [6:0] cur_width = bmc_pkg::GRID_WIDTH_RST;
  logic [6:0] cur_height = bmc_pkg::GRID_HEIGHT_RST;

  int errors = 0;
  int n_queued = 0;
  int n_begin = 0;
  int n_step = 0;
  int n_carved = 0;
  int n_done = 0;
  int n_cfg = 0;
  bit calm = 1'b0;

  backtracking_maze_carver dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_random_value(in_random_value),
    .out_strobe     (out_strobe),
    .out_carved     (out_carved),
    .out_wall_x     (out_wall_x),
    .out_wall_y     (out_wall_y),
    .out_cell_x     (out_cell_x),
    .out_cell_y     (out_cell_y),
    .out_finished   (out_finished),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report($sformatf("%s is %0d, expected %0d", name, got, want));
    end
  endtask

  task automatic queue_job(input job_t j);
    jobs.insert(jobs.size(), j);
  endtask

  function automatic int cell_of(input int x, input int y);
    return (y >> 1) * HALF_W + (x >> 1);
  endfunction

  function automatic maze_result_t carve_predict(input logic op, input logic [15:0] rnd);
    maze_result_t r;
    int w;
    int h;
    int x;
    int y;
    int nx;
    int ny;
    int cnt;
    int pick;
    int top;
    int d;
    int cand_x [4];
    int cand_y [4];
    bmc_pkg::dir_t dir;
    r = '0;
    w = int'(cur_width);
    h = int'(cur_height);
    if (w > bmc_pkg::MAX_WIDTH_DEF) begin
      w = bmc_pkg::MAX_WIDTH_DEF;
    end
    if (h > bmc_pkg::MAX_HEIGHT_DEF) begin
      h = bmc_pkg::MAX_HEIGHT_DEF;
    end
    if (op == bmc_pkg::OP_BEGIN) begin
      foreach (seen_cell[i]) seen_cell[i] = 1'b0;
      trail[0] = cell_of(1, 1);
      seen_cell[trail[0]] = 1'b1;
      trail_len = 1;
      return r;
    end
    // Pop exhausted cells until the top one has an open neighbor two squares away.
    while (trail_len > 0) begin
      top = trail[trail_len - 1];
      x = (top % HALF_W) * 2 + 1;
      y = (top / HALF_W) * 2 + 1;
      cnt = 0;
      for (d = 0; d < 4; d++) begin
        dir = bmc_pkg::dir_t'(d);
        nx = x;
        ny = y;
        case (dir)
          bmc_pkg::DIR_UP: begin
            ny = y - 2;
          end
          bmc_pkg::DIR_DOWN: begin
            ny = y + 2;
          end
          bmc_pkg::DIR_LEFT: begin
            nx = x - 2;
          end
          bmc_pkg::DIR_RIGHT: begin
            nx = x + 2;
          end
        endcase
        if (nx > 0 && ny > 0 && nx < w - 1 && ny < h - 1 && !seen_cell[cell_of(nx, ny)]) begin
          cand_x[cnt] = nx;
          cand_y[cnt] = ny;
          cnt++;
        end
      end
      if (cnt > 0) begin
        pick = int'(rnd) % cnt;
        nx = cand_x[pick];
        ny = cand_y[pick];
        seen_cell[cell_of(nx, ny)] = 1'b1;
        if (trail_len < CELLS) begin
          trail[trail_len] = cell_of(nx, ny);
          trail_len++;
        end
        r.carved = 1'b1;
        r.wall_x = 6'((x + nx) / 2);
        r.wall_y = 6'((y + ny) / 2);
        r.cell_x = 6'(nx);
        r.cell_y = 6'(ny);
        return r;
      end
      trail_len--;
    end
    r.finished = 1'b1;
    return r;
  endfunction

  task automatic add_cmd(input logic op, input logic [15:0] rnd);
    job_t j;
    j.kind = JOB_CMD;
    j.op   = op;
    j.rnd  = rnd;
    j.idx  = bmc_pkg::CFG_GRID_WIDTH;
    j.val  = '0;
    j.gap  = calm ? 0 : $urandom_range(0, 18);
    queue_job(j);
    n_queued++;
  endtask

  task automatic set_grid(input logic [6:0] w, input logic [6:0] h);
    job_t j;
    j.kind = JOB_CFG;
    j.op   = bmc_pkg::OP_BEGIN;
    j.rnd  = '0;
    j.gap  = 0;
    j.idx  = bmc_pkg::CFG_GRID_WIDTH;
    j.val  = w;
    queue_job(j);
    j.idx  = bmc_pkg::CFG_GRID_HEIGHT;
    j.val  = h;
    queue_job(j);
  endtask

  // Mostly small grids; now and then undersized, oversized or large ones.
  function automatic logic [6:0] pick_dim();
    int s;
    s = $urandom_range(0, 29);
    if (s == 0) begin
      return 7'($urandom_range(0, 2));
    end
    if (s == 1) begin
      return 7'($urandom_range(65, 127));
    end
    if (s == 2) begin
      return 7'($urandom_range(16, 64));
    end
    return 7'($urandom_range(3, 13));
  endfunction

  // Driver: holds start until the transaction is taken; grid writes wait for an idle block.
  always @(posedge clk) begin : drive_proc
    logic hold;
    logic we_next;
    job_t job;
    hold = start;
    we_next = 1'b0;
    if (rst_n) begin
      if (start && !busy) begin
        expected_q.insert(expected_q.size(), carve_predict(in_opcode, in_random_value));
        if (in_opcode == bmc_pkg::OP_BEGIN) begin
          n_begin++;
        end else begin
          n_step++;
        end
        hold = 1'b0;
      end
      if (!hold && jobs.size() > 0) begin
        if (jobs[0].kind == JOB_CFG) begin
          if (!start && expected_q.size() == 0 && !busy && !out_strobe) begin
            job = jobs.pop_front();
            we_next = 1'b1;
            cfg_index <= job.idx;
            cfg_data <= job.val;
            if (job.idx == bmc_pkg::CFG_GRID_WIDTH) begin
              cur_width = job.val;
            end else begin
              cur_height = job.val;
            end
            n_cfg++;
          end
        end else if (jobs[0].gap > 0) begin
          jobs[0].gap = jobs[0].gap - 1;
        end else begin
          job = jobs.pop_front();
          in_opcode <= job.op;
          in_random_value <= job.rnd;
          hold = 1'b1;
        end
      end
    end
    start <= hold;
    cfg_we <= we_next;
  end

  always @(posedge clk) begin : check_proc
    maze_result_t want;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        report("result strobe with no command outstanding");
      end else begin
        want = expected_q.pop_front();
        check_field("carved", out_carved, want.carved);
        check_field("wall_x", out_wall_x, want.wall_x);
        check_field("wall_y", out_wall_y, want.wall_y);
        check_field("cell_x", out_cell_x, want.cell_x);
        check_field("cell_y", out_cell_y, want.cell_y);
        check_field("finished", out_finished, want.finished);
        if (want.carved) begin
          n_carved++;
        end
        if (want.finished) begin
          n_done++;
        end
      end
    end
  end

  initial begin : stim_proc
    logic [6:0] w;
    logic [6:0] h;
    int ew;
    int eh;
    int cells;
    int steps;
    // A step with nothing on the stack reports finished.
    add_cmd(bmc_pkg::OP_STEP, 16'h0000);
    add_cmd(bmc_pkg::OP_BEGIN, 16'hFFFF);
    add_cmd(bmc_pkg::OP_STEP, 16'h0000);
    add_cmd(bmc_pkg::OP_STEP, 16'hFFFF);
    add_cmd(bmc_pkg::OP_STEP, 16'h5555);
    add_cmd(bmc_pkg::OP_STEP, 16'hAAAA);
    // Shrinking the grid mid-maze leaves no open neighbor, so the stack drains.
    set_grid(7'd3, 7'd3);
    add_cmd(bmc_pkg::OP_STEP, 16'h0001);
    add_cmd(bmc_pkg::OP_STEP, 16'h0002);
    add_cmd(bmc_pkg::OP_BEGIN, 16'h0000);
    add_cmd(bmc_pkg::OP_STEP, 16'h0000);
    set_grid(7'd127, 7'd0);
    add_cmd(bmc_pkg::OP_BEGIN, 16'h1234);
    add_cmd(bmc_pkg::OP_STEP, 16'hFFFF);
    set_grid(7'd64, 7'd64);
    add_cmd(bmc_pkg::OP_BEGIN, 16'h0000);
    add_cmd(bmc_pkg::OP_STEP, 16'h8000);
    add_cmd(bmc_pkg::OP_STEP, 16'h7FFF);
    add_cmd(bmc_pkg::OP_STEP, 16'h0001);
    // Oversized registers count as the maximum grid.
    set_grid(7'd127, 7'd127);
    add_cmd(bmc_pkg::OP_STEP, 16'hFFFE);
    add_cmd(bmc_pkg::OP_STEP, 16'h0003);
    set_grid(7'd5, 7'd5);
    add_cmd(bmc_pkg::OP_BEGIN, 16'h0000);
    repeat (5) add_cmd(bmc_pkg::OP_STEP, 16'($urandom_range(0, 65535)));

    while (n_queued < N_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      w = pick_dim();
      h = pick_dim();
      set_grid(w, h);
      ew = (int'(w) > bmc_pkg::MAX_WIDTH_DEF) ? bmc_pkg::MAX_WIDTH_DEF : int'(w);
      eh = (int'(h) > bmc_pkg::MAX_HEIGHT_DEF) ? bmc_pkg::MAX_HEIGHT_DEF : int'(h);
      cells = ((ew - 1) / 2) * ((eh - 1) / 2);
      steps = $urandom_range(1, (cells + 2 > 60) ? 60 : cells + 2);
      if ($urandom_range(0, 7) != 0) begin
        add_cmd(bmc_pkg::OP_BEGIN, 16'($urandom_range(0, 65535)));
      end
      repeat (steps) begin
        if ($urandom_range(0, 49) == 0) begin
          set_grid(pick_dim(), pick_dim());
        end
        if ($urandom_range(0, 39) == 0) begin
          add_cmd(bmc_pkg::OP_BEGIN, 16'($urandom_range(0, 65535)));
        end else begin
          add_cmd(bmc_pkg::OP_STEP, 16'($urandom_range(0, 65535)));
        end
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // Wait until every queued command has been taken and its result checked.
    while ((n_begin + n_step) < n_queued || expected_q.size() > 0) begin
      @(posedge clk);
    end
    repeat (30) @(posedge clk);
    $display("Ran %0d begins and %0d steps over %0d grid register writes.",
             n_begin, n_step, n_cfg);
    $display("Checked %0d carved walls and %0d finished mazes.", n_carved, n_done);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("backtracking_maze_carver: match");
    end else begin
      $display("backtracking_maze_carver: mismatch");
    end
    $finish;
  end

  // Room for every command being a full begin sweep after the longest gap, several times over.
  initial begin : watchdog_proc
    #30000000;
    $display("backtracking_maze_carver: mismatch");
    $finish;
  end

endmodule

[sim.f]
src/bmc_pkg.sv
src/bmc_ucode_rom.sv
src/bmc_sequencer.sv
src/bmc_datapath.sv
src/backtracking_maze_carver.sv
src/bmc_checker.sv
sim/tb_backtracking_maze_carver.sv
